[hw/rtl/dual_motor_slew_limiter_defines.svh]
// Assertion macros shared by the slew limiter RTL.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef DUAL_MOTOR_SLEW_LIMITER_DEFINES_SVH
`define DUAL_MOTOR_SLEW_LIMITER_DEFINES_SVH

// expression holds at every edge out of reset
`define DMSL_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DMSL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define DMSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dmsl_pkg.sv]
// Package for the dual motor slew limiter: item types, register codes, reset values.
// No dependencies.
`default_nettype none

package dmsl_pkg;

	localparam int SPEED_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int STEP_W     = 31; // 15-bit rate times 16-bit elapsed

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE = 2'd2;

	localparam logic [14:0] DEADZONE_RST   = 15'd3277;
	localparam logic [14:0] MAX_RATE_RST   = 15'd33;
	localparam logic [7:0]  DUTY_SCALE_RST = 8'd180;

	localparam logic REQ_SET_TARGET = 1'b0;
	localparam logic REQ_TICK       = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic [15:0]        elapsed_ms;
	} req_item_t;

	typedef struct packed {
		logic [7:0] left_duty;
		logic       left_reverse;
		logic [7:0] right_duty;
		logic       right_reverse;
	} rsp_item_t;

	// control from the top level to each lane
	typedef struct packed {
		logic set_tgt;  // latch a new conditioned target
		logic tick;     // slew current toward target
		logic load_out; // form the duty product
	} lane_ctrl_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       reverse;
	} lane_res_t;

endpackage

`default_nettype wire

[hw/rtl/dmsl_lane.sv]
// One wheel lane: deadzone conditioning, target/current state, slew and duty product.
// Depends on dmsl_pkg.
`default_nettype none

module dmsl_lane #(
	parameter int SPEED_BITS = dmsl_pkg::SPEED_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire dmsl_pkg::lane_ctrl_t        ctrl,
	input  wire signed [15:0]                speed,
	input  wire [dmsl_pkg::STEP_W-1:0]       step,
	input  wire [14:0]                       deadzone,
	input  wire [7:0]                        duty_scale,
	output dmsl_pkg::lane_res_t              res
);

	localparam int CW = (SPEED_BITS > 16) ? SPEED_BITS : 16;
	localparam int DW = (SPEED_BITS + 2 > dmsl_pkg::STEP_W + 2) ?
		SPEED_BITS + 2 : dmsl_pkg::STEP_W + 2;
	localparam int PW = SPEED_BITS + 7;
	localparam logic [CW-1:0] FS = CW'((64'd1 << (SPEED_BITS - 1)) - 64'd1);

	logic signed [SPEED_BITS-1:0] target_q;
	logic signed [SPEED_BITS-1:0] current_q;
	logic [PW-1:0]                prod_s2;
	logic                         rev_s2;

	// deadzone conditioning
	logic signed [16:0]           s_x;
	logic [15:0]                  mag_in;
	logic [CW-1:0]                mag_c;
	logic [CW-1:0]                mag_dz;
	logic [CW-1:0]                mag_lim;
	logic [CW+2:0]                mag5;
	logic [SPEED_BITS-2:0]        mag_f;
	logic signed [SPEED_BITS-1:0] tgt_new;

	always_comb begin
		s_x     = 17'(speed);
		mag_in  = speed[15] ? 16'(-s_x) : unsigned'(speed);
		mag_c   = (CW'(mag_in) >= FS) ? FS : CW'(mag_in);
		mag5    = (CW+3)'(mag_c) + ((CW+3)'(mag_c) << 2);
		if (mag_c < CW'(deadzone)) begin
			mag_dz = (mag5 < (CW+3)'(deadzone)) ? '0 : CW'(deadzone);
		end else begin
			mag_dz = mag_c;
		end
		mag_lim = (mag_dz > FS) ? FS : mag_dz;
		mag_f   = mag_lim[SPEED_BITS-2:0];
		tgt_new = speed[15] ? -signed'({1'b0, mag_f}) : signed'({1'b0, mag_f});
	end

	// slew: move by at most step
	logic signed [DW-1:0]         d_w;
	logic signed [DW-1:0]         st_w;
	logic signed [DW-1:0]         d_c;
	logic signed [SPEED_BITS-1:0] cur_new;

	always_comb begin
		d_w  = DW'(target_q) - DW'(current_q);
		st_w = signed'(DW'(step));
		if (d_w > st_w) begin
			d_c = st_w;
		end else if (d_w < -st_w) begin
			d_c = -st_w;
		end else begin
			d_c = d_w;
		end
		cur_new = current_q + signed'(d_c[SPEED_BITS-1:0]);
	end

	// duty product from the updated current speed
	logic signed [SPEED_BITS-1:0] cur_abs;
	logic [SPEED_BITS-2:0]        mag_cur;

	always_comb begin
		cur_abs = current_q[SPEED_BITS-1] ? -current_q : current_q;
		mag_cur = cur_abs[SPEED_BITS-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			current_q <= '0;
		end else begin
			if (ctrl.set_tgt) begin
				target_q <= tgt_new;
			end
			if (ctrl.tick) begin
				current_q <= cur_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			prod_s2 <= PW'(mag_cur) * PW'(duty_scale);
			rev_s2  <= current_q[SPEED_BITS-1];
		end
	end

	// |current| <= full scale, so the scaled duty always fits 8 bits
	assign res.duty    = prod_s2[PW-1:SPEED_BITS-1];
	assign res.reverse = rev_s2;

endmodule

`default_nettype wire

[hw/rtl/dmsl_merge.sv]
// Merge stage: joins both lane results into one result item and holds it for the consumer.
// Depends on dmsl_pkg.
`default_nettype none

module dmsl_merge (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       lanes_valid,
	input  wire dmsl_pkg::lane_res_t  left_res,
	input  wire dmsl_pkg::lane_res_t  right_res,
	output logic                      take,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output dmsl_pkg::rsp_item_t       rsp
);

	logic                valid_q;
	dmsl_pkg::rsp_item_t rsp_q;

	assign take      = lanes_valid && (!valid_q || !rsp_stall);
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.left_duty     <= left_res.duty;
			rsp_q.left_reverse  <= left_res.reverse;
			rsp_q.right_duty    <= right_res.duty;
			rsp_q.right_reverse <= right_res.reverse;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dual_motor_slew_limiter.sv]
// Dual motor slew limiter top: config registers, step multiply, two wheel lanes, merge.
// A tick item passes the step multiply, slew update, duty multiply and output register in order.
// One item in flight: a new item is accepted only once the last has left stage 1 (set_target)
//   or its result has moved to the output register (tick); a stalled output register holds it.
// Reset (arst_n low, async): targets and currents clear to zero, registers take their
//   defaults, no result pending. No clearing pass.
// Depends on dmsl_pkg, dmsl_lane, dmsl_merge and dual_motor_slew_limiter_defines.svh.
`default_nettype none
`include "dual_motor_slew_limiter_defines.svh"

module dual_motor_slew_limiter #(
	parameter int SPEED_BITS = dmsl_pkg::SPEED_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                req_valid,
	output logic                               req_stall,
	input  wire dmsl_pkg::req_item_t           req,
	output logic                               rsp_valid,
	input  wire                                rsp_stall,
	output dmsl_pkg::rsp_item_t                rsp,
	input  wire                                cfg_wr_en,
	input  wire [dmsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [dmsl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// ---------------------------------------------------------------
	// Configuration registers; an index past the list is ignored.
	// ---------------------------------------------------------------
	logic [14:0] deadzone_q;
	logic [14:0] max_rate_q;
	logic [7:0]  duty_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q   <= dmsl_pkg::DEADZONE_RST;
			max_rate_q   <= dmsl_pkg::MAX_RATE_RST;
			duty_scale_q <= dmsl_pkg::DUTY_SCALE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dmsl_pkg::REG_DEADZONE:   deadzone_q   <= cfg_wdata[14:0];
				dmsl_pkg::REG_MAX_RATE:   max_rate_q   <= cfg_wdata[14:0];
				dmsl_pkg::REG_DUTY_SCALE: duty_scale_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: capture the item and form the slew step.
	// The step is rate * elapsed, exact in 31 bits, shared by both lanes.
	// ---------------------------------------------------------------
	logic                        v1_q;
	logic                        tick_s1;
	logic signed [15:0]          left_speed_s1;
	logic signed [15:0]          right_speed_s1;
	logic [dmsl_pkg::STEP_W-1:0] step_s1;
	logic                        load_out_q;
	logic                        v2_q;
	logic                        take;
	logic                        accept;

	// one item at a time: busy from acceptance until its result moves to the output register
	assign req_stall = v1_q || load_out_q || v2_q;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			tick_s1 <= 1'b0;
		end else begin
			v1_q <= accept;
			if (accept) begin
				tick_s1 <= (req.req_type == dmsl_pkg::REQ_TICK);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_speed_s1  <= req.left_speed;
			right_speed_s1 <= req.right_speed;
			step_s1        <= dmsl_pkg::STEP_W'(max_rate_q) * dmsl_pkg::STEP_W'(req.elapsed_ms);
		end
	end

	// ---------------------------------------------------------------
	// Lane control. Stage 1 updates target or current in each lane;
	// stage 2 (tick only) holds the duty product until the merge takes it.
	// ---------------------------------------------------------------
	dmsl_pkg::lane_ctrl_t lane_ctrl;

	always_comb begin
		lane_ctrl.set_tgt  = v1_q && !tick_s1;
		lane_ctrl.tick     = v1_q && tick_s1;
		lane_ctrl.load_out = load_out_q;
	end

	// the product is formed the cycle after the current speed moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_out_q <= 1'b0;
			v2_q       <= 1'b0;
		end else begin
			load_out_q <= lane_ctrl.tick;
			if (load_out_q) begin
				v2_q <= 1'b1;
			end else if (take) begin
				v2_q <= 1'b0;
			end
		end
	end

	dmsl_pkg::lane_res_t left_res;
	dmsl_pkg::lane_res_t right_res;

	dmsl_lane #(
		.SPEED_BITS (SPEED_BITS)
	) u_lane_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.speed      (left_speed_s1),
		.step       (step_s1),
		.deadzone   (deadzone_q),
		.duty_scale (duty_scale_q),
		.res        (left_res)
	);

	dmsl_lane #(
		.SPEED_BITS (SPEED_BITS)
	) u_lane_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.speed      (right_speed_s1),
		.step       (step_s1),
		.deadzone   (deadzone_q),
		.duty_scale (duty_scale_q),
		.res        (right_res)
	);

	// ---------------------------------------------------------------
	// Merge: both lanes finish together; one result item per tick.
	// ---------------------------------------------------------------
	logic lanes_valid;

	// v2 is not yet set in the product cycle; the product is ready once v2 is
	assign lanes_valid = v2_q;

	dmsl_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lanes_valid (lanes_valid),
		.left_res    (left_res),
		.right_res   (right_res),
		.take        (take),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`DMSL_ASSERT_ALWAYS(a_one_in_flight, !(v1_q && (v2_q || load_out_q)), "two items in flight")
	`DMSL_ASSERT_NEXT(a_accept_to_s1, accept, v1_q, "accepted item did not reach stage 1")
	`DMSL_ASSERT_NEXT(a_set_no_result, v1_q && !tick_s1, !load_out_q && !v2_q, "set made result")
	`DMSL_ASSERT_IMPL(a_rsp_from_lanes, $rose(rsp_valid), $past(take), "result without lane data")

endmodule

`default_nettype wire
